// File: hw/rtl/paw3_pkg.sv
// Shared constants, status codes and sequencer states of the piecewise affine warp.
// Used by every module of the block; depends on nothing.
package paw3_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS     = 24;
   localparam int TETRAS        = 6;
   localparam int COEFS         = 12;
   localparam int MAX_CELLS_DEF = 64;
   localparam int ROWS          = 3;
   localparam int COLS          = 4;

   localparam logic [1:0] STAT_POINT = 2'd0;
   localparam logic [1:0] STAT_LOAD  = 2'd1;
   localparam logic [1:0] STAT_ERROR = 2'd2;

   localparam logic [1:0] REG_CELLS_X = 2'd0;
   localparam logic [1:0] REG_CELLS_Y = 2'd1;
   localparam logic [1:0] REG_CELLS_Z = 2'd2;
   localparam logic [1:0] REG_STEPS   = 2'd3;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_LOC,
      ST_MAC,
      ST_RESP
   } state_type;

endpackage

// File: hw/rtl/paw3_locate.sv
// Finds the grid cube and the tetrahedron of a point in three registered stages.
// Depends on paw3_pkg.
module paw3_locate
   import paw3_pkg::*;
#(
   parameter int MAX_CELLS = MAX_CELLS_DEF,
   localparam int TET_W    = $clog2(TETRAS * MAX_CELLS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] px,
   input  logic signed [WORD_BITS-1:0] py,
   input  logic signed [WORD_BITS-1:0] pz,
   input  logic [6:0]                  nx,
   input  logic [6:0]                  ny,
   input  logic [6:0]                  nz,
   input  logic [13:0]                 nxy,
   output logic                        done,
   output logic [TET_W-1:0]            tet_index
);

   localparam int TW = WORD_BITS + 8;
   localparam int LW = TW + 1;
   localparam int CW = LW + 1;

   logic [2:0]           vld_ff;
   logic signed [TW-1:0] t_ff [3];
   logic signed [TW-1:0] t_in [3];
   logic [6:0]           c_ff [3];
   logic [6:0]           c_in [3];
   logic signed [LW-1:0] l_ff [3];
   logic signed [LW-1:0] l_in [3];
   logic [TET_W-1:0]     tet_ff;
   logic [TET_W-1:0]     tet_in;
   logic signed [WORD_BITS-1:0] pv [3];
   logic [6:0]           nv [3];

   assign pv[0] = px;
   assign pv[1] = py;
   assign pv[2] = pz;
   assign nv[0] = nx;
   assign nv[1] = ny;
   assign nv[2] = nz;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t_in[k] = TW'(pv[k]) * $signed(TW'({1'b0, nv[k]}));
      end
   end

   // Cell index is floor(p*n) clamped to the grid, and the local coordinate stays exact.
   always_comb begin
      logic [15:0] f;
      for (int k = 0; k < 3; k++) begin
         f = t_ff[k][TW-1:FRAC_BITS];
         if (t_ff[k][TW-1]) begin
            c_in[k] = '0;
         end else if (f >= 16'(nv[k] - 7'd1)) begin
            c_in[k] = nv[k] - 7'd1;
         end else begin
            c_in[k] = f[6:0];
         end
         l_in[k] = LW'(t_ff[k]) - $signed(LW'({c_in[k], FRAC_BITS'(0)}));
      end
   end

   always_comb begin
      logic signed [CW-1:0] one, x, y, z, mx, my, mz;
      logic [2:0]  t;
      logic [21:0] cube;
      logic [24:0] tet;
      one = CW'(1) <<< FRAC_BITS;
      x   = CW'(l_ff[0]);
      y   = CW'(l_ff[1]);
      z   = CW'(l_ff[2]);
      mx  = one - x;
      my  = one - y;
      mz  = one - z;
      t   = '0;
      if (y < x && x <= my && y < z && z <= my) t = t + 3'd1;
      if (z <= x && x < mz && z <= y && y < mz) t = t + 3'd2;
      if (x <= z && mz < x && y <= z && mz < y) t = t + 3'd3;
      if (x < y && my <= x && z < y && my <= z) t = t + 3'd4;
      if (y <= x && mx < y && z < x && mx <= z) t = t + 3'd5;
      cube   = 22'(c_ff[0]) + 22'(c_ff[1] * nx) + 22'(c_ff[2] * nxy);
      tet    = 25'(cube) * 25'(TETRAS) + 25'(t);
      tet_in = tet[TET_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], start};
      end
      t_ff   <= t_in;
      c_ff   <= c_in;
      l_ff   <= l_in;
      tet_ff <= tet_in;
   end

   assign done      = vld_ff[2];
   assign tet_index = tet_ff;

endmodule

// File: hw/rtl/paw3_lane.sv
// One affine row lane: its coefficient bank, a multiplier and a rounding accumulator.
// Depends on paw3_pkg.
module paw3_lane
   import paw3_pkg::*;
#(
   parameter int MAX_CELLS = MAX_CELLS_DEF,
   localparam int ADDR_W   = $clog2(TETRAS * COLS * MAX_CELLS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [WORD_BITS-1:0]        wr_data,
   input  logic                        start,
   input  logic [ADDR_W-1:0]           base_addr,
   input  logic signed [WORD_BITS-1:0] px,
   input  logic signed [WORD_BITS-1:0] py,
   input  logic signed [WORD_BITS-1:0] pz,
   output logic                        done,
   output logic signed [WORD_BITS-1:0] result
);

   localparam int DEPTH = TETRAS * COLS * MAX_CELLS;
   localparam int PW    = 2 * WORD_BITS;
   localparam int AW    = PW + 4;
   localparam int SW    = AW - FRAC_BITS;

   logic [WORD_BITS-1:0]        mem [DEPTH];
   logic [2:0]                  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]           base_ff, base_in;
   logic                        rd_vld_ff;
   logic [1:0]                  rd_col_ff;
   logic signed [WORD_BITS-1:0] data_ff;
   logic                        prod_vld_ff, prod_last_ff;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic signed [AW-1:0]        acc_ff, acc_in;
   logic                        done_ff;
   logic signed [WORD_BITS-1:0] res_ff, res_in;
   logic signed [WORD_BITS-1:0] operand;
   logic                        issue;

   assign issue   = !cnt_ff[2];
   assign cnt_in  = start ? 3'd0 : (issue ? cnt_ff + 3'd1 : cnt_ff);
   assign base_in = start ? base_addr : base_ff;

   always_comb begin
      case (rd_col_ff)
         2'd0:    operand = px;
         2'd1:    operand = py;
         2'd2:    operand = pz;
         default: operand = WORD_BITS'(1) <<< FRAC_BITS;
      endcase
      prod_in = PW'(data_ff) * PW'(operand);
   end

   // Rounds half up, then saturates the row to the word range.
   always_comb begin
      logic signed [AW-1:0] sum;
      logic signed [SW-1:0] s;
      sum = acc_ff + AW'(prod_ff);
      s   = SW'(sum >>> FRAC_BITS);
      if (s > $signed(SW'({1'b0, {(WORD_BITS-1){1'b1}}}))) begin
         res_in = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (s < $signed(~SW'({1'b0, {(WORD_BITS-1){1'b1}}}))) begin
         res_in = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         res_in = s[WORD_BITS-1:0];
      end
      if (start) begin
         acc_in = AW'(1) <<< (FRAC_BITS - 1);
      end else if (prod_vld_ff) begin
         acc_in = sum;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_ff <= mem[base_ff + ADDR_W'(cnt_ff[1:0])];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 3'd4;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= issue && !start;
         prod_vld_ff  <= rd_vld_ff;
         prod_last_ff <= rd_vld_ff && (rd_col_ff == 2'd3);
         done_ff      <= prod_last_ff;
      end
      base_ff   <= base_in;
      rd_col_ff <= cnt_ff[1:0];
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      if (prod_last_ff) begin
         res_ff <= res_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// File: hw/rtl/piecewise_affine_warp_3d.sv
// Top level of the 3-D piecewise affine warp: sequencer, three row lanes and the merge.
// Depends on paw3_pkg, paw3_locate and paw3_lane.
//
//   channel  | direction | ports
//   request  | in        | req_valid, req_ready, req_mode .. req_point_z
//   response | out       | rsp_valid, rsp_ready, rsp_out_x .. rsp_status
//   csr      | in        | csr_we, csr_index, csr_wdata
//
// A load request goes straight to its response. A point request runs step_count passes,
// each a setup state, three locate stages and the lanes, which read their four
// coefficients one per cycle from a bank of their own each.
// Sync reset idles control and sets each CSR to 1; the table holds nothing until written.
// A waiting response holds the sequencer in its last state; no new request is taken then.
module piecewise_affine_warp_3d
   import paw3_pkg::*;
#(
   parameter int MAX_CELLS = MAX_CELLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [12:0]                 req_coef_index,
   input  logic signed [31:0]          req_coef_value,
   input  logic signed [31:0]          req_point_x,
   input  logic signed [31:0]          req_point_y,
   input  logic signed [31:0]          req_point_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_out_x,
   output logic signed [31:0]          rsp_out_y,
   output logic signed [31:0]          rsp_out_z,
   output logic [1:0]                  rsp_status,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [7:0]                  csr_wdata
);

   localparam int TET_W  = $clog2(TETRAS * MAX_CELLS);
   localparam int ADDR_W = TET_W + 2;
   localparam int TABLE_WORDS = COEFS * TETRAS * MAX_CELLS;

   state_type state_ff, state_in;

   logic [6:0]  nx_ff, ny_ff, nz_ff;
   logic [7:0]  steps_cfg_ff;
   logic [13:0] nxy_ff, nxy_in;
   logic [7:0]  steps_ff, steps_in;
   logic signed [WORD_BITS-1:0] p_ff [3];
   logic signed [WORD_BITS-1:0] p_in [3];
   logic [1:0]  stat_ff, stat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic [1:0]  ostat_ff;

   logic        accept, grid_bad, idx_bad;
   logic [20:0] grid_cells;
   logic [24:0] quot_full;
   logic [12:0] quot;
   logic [3:0]  entry;
   logic [1:0]  wr_row;
   logic [ADDR_W-1:0] wr_addr;
   logic        loc_start, loc_done, lane_start, rsp_load;
   logic [TET_W-1:0] tet_index;
   logic [ROWS-1:0]  lane_done;
   logic signed [WORD_BITS-1:0] lane_res [ROWS];

   assign accept     = req_valid && req_ready;
   assign grid_cells = 21'(nx_ff) * 21'(ny_ff) * 21'(nz_ff);
   assign grid_bad   = (nx_ff == '0) || (ny_ff == '0) || (nz_ff == '0)
                       || (grid_cells > 21'(MAX_CELLS));
   assign idx_bad    = 32'(req_coef_index) >= 32'(TABLE_WORDS);
   assign nxy_in     = nx_ff * ny_ff;

   // Index split into tetrahedron and entry by a reciprocal multiply for the divide by twelve.
   assign quot_full = 25'(req_coef_index) * 25'd2731;
   assign quot      = quot_full[24:12] >> 3;
   assign entry     = 4'(req_coef_index - 13'(quot * 13'(COEFS)));
   assign wr_row    = (entry >= 4'd8) ? 2'd2 : ((entry >= 4'd4) ? 2'd1 : 2'd0);
   assign wr_addr   = {quot[TET_W-1:0], entry[1:0]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_LOAD || grid_bad || steps_cfg_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: state_in = ST_LOC;
         ST_LOC:  if (loc_done) state_in = ST_MAC;
         ST_MAC: begin
            if (&lane_done) begin
               state_in = (steps_ff == 8'd1) ? ST_RESP : ST_STEP;
            end
         end
         ST_RESP: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      loc_start    = (state_ff == ST_STEP);
      lane_start   = (state_ff == ST_LOC) && loc_done;
      rsp_load     = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);
      steps_in     = steps_ff;
      stat_in      = stat_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
      if (accept) begin
         steps_in = steps_cfg_ff;
         if (req_mode == MODE_LOAD) begin
            stat_in = idx_bad ? STAT_ERROR : STAT_LOAD;
            for (int k = 0; k < 3; k++) p_in[k] = '0;
         end else if (grid_bad) begin
            stat_in = STAT_ERROR;
            for (int k = 0; k < 3; k++) p_in[k] = '0;
         end else begin
            stat_in = STAT_POINT;
            p_in[0] = req_point_x;
            p_in[1] = req_point_y;
            p_in[2] = req_point_z;
         end
      end
      if (state_ff == ST_MAC && (&lane_done)) begin
         steps_in = steps_ff - 8'd1;
         for (int k = 0; k < ROWS; k++) p_in[k] = lane_res[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nx_ff        <= 7'd1;
         ny_ff        <= 7'd1;
         nz_ff        <= 7'd1;
         steps_cfg_ff <= 8'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_CELLS_X: nx_ff        <= csr_wdata[6:0];
               REG_CELLS_Y: ny_ff        <= csr_wdata[6:0];
               REG_CELLS_Z: nz_ff        <= csr_wdata[6:0];
               REG_STEPS:   steps_cfg_ff <= csr_wdata;
               default:     ;
            endcase
         end
      end
      nxy_ff   <= nxy_in;
      steps_ff <= steps_in;
      stat_ff  <= stat_in;
      p_ff     <= p_in;
      if (rsp_load) begin
         ox_ff    <= p_ff[0];
         oy_ff    <= p_ff[1];
         oz_ff    <= p_ff[2];
         ostat_ff <= stat_ff;
      end
   end

   paw3_locate #(.MAX_CELLS(MAX_CELLS)) u_locate (
      .clock     (clock),
      .reset     (reset),
      .start     (loc_start),
      .px        (p_ff[0]),
      .py        (p_ff[1]),
      .pz        (p_ff[2]),
      .nx        (nx_ff),
      .ny        (ny_ff),
      .nz        (nz_ff),
      .nxy       (nxy_ff),
      .done      (loc_done),
      .tet_index (tet_index)
   );

   for (genvar r = 0; r < ROWS; r++) begin : g_lane
      paw3_lane #(.MAX_CELLS(MAX_CELLS)) u_lane (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (accept && req_mode == MODE_LOAD && !idx_bad && wr_row == 2'(r)),
         .wr_addr   (wr_addr),
         .wr_data   (req_coef_value),
         .start     (lane_start),
         .base_addr ({tet_index, 2'b00}),
         .px        (p_ff[0]),
         .py        (p_ff[1]),
         .pz        (p_ff[2]),
         .done      (lane_done[r]),
         .result    (lane_res[r])
      );
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = ox_ff;
   assign rsp_out_y  = oy_ff;
   assign rsp_out_z  = oz_ff;
   assign rsp_status = ostat_ff;

endmodule
